### rtl/pcw_pkg.sv
// Shared constants, widths and control types of the path curvature window unit.
package pcw_pkg;

    // Number of path points held in the sliding window (3 .. 64).
    localparam int WINDOW = 8;

    localparam int PT_W   = 20;                      // coordinate width
    localparam int ERR_W  = 32;                      // result width
    localparam int D_W    = PT_W + 1;                // coordinate difference
    localparam int PROD_W = 2 * D_W;                 // one product
    localparam int SUM_W  = PROD_W + 1 + $clog2(WINDOW); // sum of cross products
    localparam int Q_W    = PROD_W;                  // squared chord length
    localparam int FRAC_W = 8;                       // fraction bits of the chord length
    localparam int RAD_W  = Q_W + 2 * FRAC_W;        // square root radicand
    localparam int L_W    = RAD_W / 2;               // chord length with fraction
    localparam int SQ_REM_W = L_W + 2;               // square root remainder
    localparam int NUM_W  = SUM_W + FRAC_W + 2;      // dividend
    localparam int DIV_W  = L_W + 1;                 // divisor
    localparam int QUO_W  = ERR_W + 1;               // quotient bits produced
    localparam int DR_W   = DIV_W + QUO_W;           // division working width

    localparam int PTR_W  = $clog2(WINDOW);          // window memory address
    localparam int CNT_W  = $clog2(WINDOW + 1);      // fill count
    localparam int RAM_W  = 2 * PT_W;                // one stored point

    localparam int STEP_MAX = (L_W > QUO_W) ? ((L_W > WINDOW) ? L_W : WINDOW)
                                            : ((QUO_W > WINDOW) ? QUO_W : WINDOW);
    localparam int STEP_W = $clog2(STEP_MAX + 1);

    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_b;     // latch the incoming point as the newest point B
        logic ld_a;       // latch the oldest point A and the chord vector
        logic mul_sq;     // square the chord components
        logic q_ld;       // form the squared chord length, clear the sum
        logic mul_cross;  // cross product terms of one inner point
        logic acc;        // accumulate one cross product
        logic sq_init;    // start the square root, take the magnitude of the sum
        logic sq_step;    // one square root digit
        logic div_init;   // form dividend and divisor
        logic div_ovf;    // overflow check and division setup
        logic div_step;   // one quotient bit
        logic res_load;   // load the output register
        logic res_full;   // the loaded result comes from a full window
    } pcw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic q_zero;     // chord length is zero
    } pcw_stat_t;

endpackage

### rtl/pcw_if.sv
// Handshake interfaces for path points in and curvature results out.
interface pcw_point_if import pcw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PT_W-1:0]  pos_x;
    logic signed [PT_W-1:0]  pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface pcw_result_if import pcw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] curve_error;
    logic                    error_valid;
    logic                    chord_zero;

    modport source (output valid, output curve_error, output error_valid,
                    output chord_zero, input ready);
    modport sink   (input valid, input curve_error, input error_valid,
                    input chord_zero, output ready);
endinterface

### rtl/pcw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/pcw_ctrl.sv
// Controller of the path curvature window unit: sequencing, window pointers, handshakes.
module pcw_ctrl import pcw_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output pcw_cmd_t         cmd,
    input  pcw_stat_t        stat,
    output logic [PTR_W-1:0] wr_addr,
    output logic             rd_en,
    output logic [PTR_W-1:0] rd_addr
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LDA,
        S_SQ,
        S_QSUM,
        S_MUL,
        S_ACC,
        S_SQI,
        S_SQRT,
        S_DIVI,
        S_OVF,
        S_DIV,
        S_RES
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               full_reg, full_next;
    logic               out_valid_reg, out_valid_next;
    logic               in_xfer;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW - 1)) ? '0 : p + 1'b1;
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign wr_addr   = wr_ptr_reg;

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        fill_next      = fill_reg;
        step_next      = step_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_ptr_reg;
        cmd            = '0;

        cmd.take_b = in_xfer;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                    if (fill_reg != CNT_W'(WINDOW))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (fill_reg >= CNT_W'(WINDOW - 1))
                    begin
                        // The slot after the one written now holds the oldest point.
                        full_next   = 1'b1;
                        rd_en       = 1'b1;
                        rd_addr     = ptr_inc(wr_ptr_reg);
                        rd_ptr_next = ptr_inc(wr_ptr_reg);
                        state_next  = S_LDA;
                    end
                    else
                    begin
                        full_next  = 1'b0;
                        state_next = S_RES;
                    end
                end
            end
            S_LDA:
            begin
                cmd.ld_a    = 1'b1;
                rd_en       = 1'b1;
                rd_addr     = ptr_inc(rd_ptr_reg);
                rd_ptr_next = ptr_inc(rd_ptr_reg);
                step_next   = STEP_W'(1);
                state_next  = S_SQ;
            end
            S_SQ:
            begin
                cmd.mul_sq = 1'b1;
                state_next = S_QSUM;
            end
            S_QSUM:
            begin
                cmd.q_ld   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_cross = 1'b1;
                if (step_reg != STEP_W'(WINDOW - 2))
                begin
                    rd_en       = 1'b1;
                    rd_addr     = ptr_inc(rd_ptr_reg);
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                end
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (step_reg == STEP_W'(WINDOW - 2))
                begin
                    state_next = S_SQI;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_SQI:
            begin
                cmd.sq_init = 1'b1;
                step_next   = '0;
                state_next  = stat.q_zero ? S_RES : S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sq_step = 1'b1;
                if (step_reg == STEP_W'(L_W - 1))
                begin
                    state_next = S_DIVI;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_OVF;
            end
            S_OVF:
            begin
                cmd.div_ovf = 1'b1;
                step_next   = '0;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    state_next = S_RES;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_RES:
            begin
                cmd.res_full = full_reg;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            step_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            step_reg      <= step_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count ran past the window size");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_ACC) |->
        (step_reg >= STEP_W'(1) && step_reg <= STEP_W'(WINDOW - 2)))
        else $error("inner point index out of range during the walk");

    a_partial_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && fill_reg < CNT_W'(WINDOW - 1)) |=>
        (state_reg == S_RES && !full_reg))
        else $error("partial window did not go straight to the result");

    a_out_from_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RES))
        else $error("result presented outside the result state");
`endif

endmodule

### rtl/pcw_dp.sv
// Datapath of the path curvature window unit: cross products, square root, division.
module pcw_dp import pcw_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcw_cmd_t                cmd,
    output pcw_stat_t               stat,
    input  logic signed [PT_W-1:0]  pos_x,
    input  logic signed [PT_W-1:0]  pos_y,
    input  logic [RAM_W-1:0]        rd_data,
    output logic signed [ERR_W-1:0] curve_error,
    output logic                    error_valid,
    output logic                    chord_zero
);

    localparam logic [QUO_W-1:0] QUO_POS_LIM = QUO_W'({(ERR_W-1){1'b1}});
    localparam logic [QUO_W-1:0] QUO_NEG_LIM = QUO_W'(1) << (ERR_W - 1);

    logic signed [PT_W-1:0]   bx_reg, by_reg, ax_reg, ay_reg;
    logic signed [D_W-1:0]    abx_reg, aby_reg;
    logic signed [PROD_W-1:0] prod1_reg, prod2_reg;
    logic [Q_W-1:0]           q_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [L_W-1:0]           root_reg;
    logic [SQ_REM_W-1:0]      sqrem_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DIV_W-1:0]         div_reg;
    logic [DR_W-1:0]          rem_reg, dsh_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic                     ovf_reg;
    logic signed [ERR_W-1:0]  last_err_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic                     evalid_reg, czero_reg;

    logic signed [PT_W-1:0]   rd_x, rd_y;
    logic signed [D_W-1:0]    apx, apy;
    logic signed [D_W-1:0]    m1_a, m1_b, m2_a, m2_b;
    logic signed [PROD_W-1:0] m1, m2;
    logic [SQ_REM_W+1:0]      sq_sh, sq_trial;
    logic                     sq_ge;
    logic                     div_ge;
    logic [QUO_W-1:0]         neg_q;
    logic signed [ERR_W-1:0]  sat_err;

    assign rd_x = rd_data[RAM_W-1:PT_W];
    assign rd_y = rd_data[PT_W-1:0];
    assign apx  = D_W'(rd_x) - D_W'(ax_reg);
    assign apy  = D_W'(rd_y) - D_W'(ay_reg);

    // One multiplier pair serves both the chord squares and the cross products.
    assign m1_a = abx_reg;
    assign m1_b = cmd.mul_sq ? abx_reg : apy;
    assign m2_a = cmd.mul_sq ? aby_reg : apx;
    assign m2_b = aby_reg;
    assign m1   = m1_a * m1_b;
    assign m2   = m2_a * m2_b;

    // Digit by digit square root, two radicand bits a step.
    assign sq_sh    = {sqrem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = (SQ_REM_W + 2)'({root_reg, 2'b01});
    assign sq_ge    = (sq_sh >= sq_trial);

    assign div_ge = (rem_reg >= dsh_reg);

    assign stat.q_zero = (q_reg == '0);

    always_comb
    begin
        neg_q = QUO_W'(0) - quo_reg;
        if (neg_reg)
        begin
            sat_err = (ovf_reg || quo_reg > QUO_NEG_LIM) ? ERR_MIN : neg_q[ERR_W-1:0];
        end
        else
        begin
            sat_err = (ovf_reg || quo_reg > QUO_POS_LIM) ? ERR_MAX : quo_reg[ERR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_b)
        begin
            bx_reg <= pos_x;
            by_reg <= pos_y;
        end
        if (cmd.ld_a)
        begin
            ax_reg  <= rd_x;
            ay_reg  <= rd_y;
            abx_reg <= D_W'(bx_reg) - D_W'(rd_x);
            aby_reg <= D_W'(by_reg) - D_W'(rd_y);
        end
        if (cmd.mul_sq || cmd.mul_cross)
        begin
            prod1_reg <= m1;
            prod2_reg <= m2;
        end
        if (cmd.q_ld)
        begin
            q_reg   <= $unsigned(prod1_reg) + $unsigned(prod2_reg);
            sum_reg <= '0;
        end
        if (cmd.acc)
        begin
            sum_reg <= sum_reg + SUM_W'(prod1_reg) - SUM_W'(prod2_reg);
        end
        if (cmd.sq_init)
        begin
            rad_reg   <= {q_reg, (2 * FRAC_W)'(0)};
            root_reg  <= '0;
            sqrem_reg <= '0;
            neg_reg   <= sum_reg[SUM_W-1];
            mag_reg   <= sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
        end
        if (cmd.sq_step)
        begin
            rad_reg  <= rad_reg << 2;
            root_reg <= {root_reg[L_W-2:0], sq_ge};
            if (sq_ge)
            begin
                sqrem_reg <= SQ_REM_W'(sq_sh - sq_trial);
            end
            else
            begin
                sqrem_reg <= SQ_REM_W'(sq_sh);
            end
        end
        if (cmd.div_init)
        begin
            // Rounded quotient: (2 * |S| * 2^8 + L) / (2 * L).
            num_reg <= (NUM_W'(mag_reg) << (FRAC_W + 1)) + NUM_W'(root_reg);
            div_reg <= {root_reg, 1'b0};
        end
        if (cmd.div_ovf)
        begin
            ovf_reg <= (DR_W'(num_reg) >= {div_reg, QUO_W'(0)});
            rem_reg <= DR_W'(num_reg);
            dsh_reg <= DR_W'({div_reg, (QUO_W - 1)'(0)});
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
            if (div_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
        end
        if (cmd.res_load)
        begin
            if (!cmd.res_full)
            begin
                err_reg    <= last_err_reg;
                evalid_reg <= 1'b0;
                czero_reg  <= 1'b0;
            end
            else if (stat.q_zero)
            begin
                err_reg    <= '0;
                evalid_reg <= 1'b1;
                czero_reg  <= 1'b1;
            end
            else
            begin
                err_reg    <= sat_err;
                evalid_reg <= 1'b1;
                czero_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
        end
        else if (cmd.res_load && cmd.res_full)
        begin
            last_err_reg <= stat.q_zero ? '0 : sat_err;
        end
    end

    assign curve_error = err_reg;
    assign error_valid = evalid_reg;
    assign chord_zero  = czero_reg;

endmodule

### rtl/path_curvature_window_unit.sv
// Top level of the path curvature window unit: controller, datapath and window memory.
//
// The unit takes one tracked line point (pos_x, pos_y) per transfer on the point
// channel and keeps the last WINDOW points in a small circular memory. Every point
// produces exactly one transfer on the result channel. Until WINDOW points have
// arrived, the result repeats the previous error (zero after reset) with error_valid
// low. Once the window is full, curve_error is the sum of the signed perpendicular
// distances of the inner points from the chord running from the oldest to the newest
// point, in position units, rounded half away from zero and saturated to 32 bits;
// a chord of zero length gives zero with chord_zero set. When the output register is
// free, a point that does not fill the window has its result loaded in the cycle after
// its transfer. A point with a full window has its result loaded after the window walk,
// the square root and the division; when the chord has zero length, the square root
// and the division are skipped. A result that still waits for its transfer holds the
// next one back in the result state for as long as it waits. The controller walks the
// window one memory read at a time through one multiplier pair, then runs a 29 step
// square root of the squared chord length and a 33 step restoring division. The unit
// works on one point at a time and takes the next point the cycle after a result is
// loaded into the output register, even while that result still waits for its
// transfer.
module path_curvature_window_unit import pcw_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    pcw_point_if.sink      point,
    pcw_result_if.source   result
);

    pcw_cmd_t          cmd;
    pcw_stat_t         stat;
    logic [PTR_W-1:0]  wr_addr;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [RAM_W-1:0]  rd_data;
    logic              in_ready;
    logic              point_xfer;

    assign point.ready = in_ready;
    assign point_xfer  = point.valid && in_ready;

    // Sequencing, window pointers and fill count.
    pcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (in_ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    // Window store: one entry per point, x in the upper half, y in the lower half.
    // Every incoming point is written in the cycle of its transfer.
    pcw_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk     (clk),
        .wr_en   (point_xfer),
        .wr_addr (wr_addr),
        .wr_data ({point.pos_x, point.pos_y}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Arithmetic and the output register.
    pcw_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .pos_x       (point.pos_x),
        .pos_y       (point.pos_y),
        .rd_data     (rd_data),
        .curve_error (result.curve_error),
        .error_valid (result.error_valid),
        .chord_zero  (result.chord_zero)
    );

endmodule

### tb/sv/path_curvature_window_checker.sv
`timescale 1ns / 1ps
// Checker for the path curvature window unit: predicts each result, compares field by field.
module path_curvature_window_checker import pcw_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    pcw_point_if  point,
    pcw_result_if result,
    output int    mismatches,
    output int    pending
);

    typedef struct packed {
        logic signed [ERR_W-1:0] curve_error;
        logic                    error_valid;
        logic                    chord_zero;
    } curve_result_t;

    curve_result_t           expected_q[$];
    logic signed [PT_W-1:0]  win_x [WINDOW];
    logic signed [PT_W-1:0]  win_y [WINDOW];
    int                      fill;
    logic signed [ERR_W-1:0] held_error;
    int                      fails;

    // Integer square root, one result bit per pass.
    function automatic longint unsigned chord_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned rest;
        longint unsigned step_bit;
        root     = 0;
        rest     = n;
        step_bit = 64'h1 << 62;
        while (step_bit > rest)
            step_bit >>= 2;
        while (step_bit != 0)
        begin
            if (rest >= root + step_bit)
            begin
                rest = rest - (root + step_bit);
                root = (root >> 1) + step_bit;
            end
            else
            begin
                root >>= 1;
            end
            step_bit >>= 2;
        end
        return root;
    endfunction

    // Enters one point into the window and returns the result it causes.
    function automatic curve_result_t track_point(input logic signed [PT_W-1:0] px,
                                                  input logic signed [PT_W-1:0] py);
        curve_result_t   r;
        longint          abx;
        longint          aby;
        longint          apx;
        longint          apy;
        longint          cross_sum;
        longint unsigned sq_len;
        longint unsigned len8;
        longint unsigned mag;
        longint unsigned quo;
        if (fill < WINDOW)
        begin
            win_x[fill] = px;
            win_y[fill] = py;
            fill++;
        end
        else
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                win_x[i] = win_x[i + 1];
                win_y[i] = win_y[i + 1];
            end
            win_x[WINDOW - 1] = px;
            win_y[WINDOW - 1] = py;
        end

        r.curve_error = held_error;
        r.error_valid = 1'b0;
        r.chord_zero  = 1'b0;
        if (fill < WINDOW)
            return r;

        abx = longint'(win_x[WINDOW - 1]) - longint'(win_x[0]);
        aby = longint'(win_y[WINDOW - 1]) - longint'(win_y[0]);
        cross_sum = 0;
        for (int i = 1; i < WINDOW - 1; i++)
        begin
            apx = longint'(win_x[i]) - longint'(win_x[0]);
            apy = longint'(win_y[i]) - longint'(win_y[0]);
            cross_sum += abx * apy - apx * aby;
        end

        sq_len = unsigned'(abx * abx + aby * aby);
        if (sq_len == 0)
        begin
            r.curve_error = '0;
            r.chord_zero  = 1'b1;
        end
        else
        begin
            // Chord length carries 8 fraction bits; the quotient is rounded half away from zero.
            len8 = chord_root(sq_len << 16);
            mag  = (cross_sum < 0) ? unsigned'(-cross_sum) : unsigned'(cross_sum);
            quo  = ((mag << 9) + len8) / (len8 << 1);
            if (cross_sum < 0)
                r.curve_error = (quo > 64'd2147483648) ? ERR_MIN : ERR_W'(-longint'(quo));
            else
                r.curve_error = (quo > 64'd2147483647) ? ERR_MAX : ERR_W'(quo);
        end
        r.error_valid = 1'b1;
        held_error    = r.curve_error;
        return r;
    endfunction

    task automatic check_field(input string field, input logic signed [ERR_W-1:0] want,
                               input logic signed [ERR_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fails++;
        end
    endtask

    // The result is handled before the point of the same edge, since a point is never
    // answered in the cycle of its own transfer.
    always @(posedge clk or negedge rst_n)
    begin : watch
        curve_result_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            fill       = 0;
            held_error = '0;
            fails      = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transfer: curve_error %0d", result.curve_error);
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("curve_error", want.curve_error, result.curve_error);
                    check_field("error_valid", ERR_W'(want.error_valid),
                                ERR_W'(result.error_valid));
                    check_field("chord_zero", ERR_W'(want.chord_zero),
                                ERR_W'(result.chord_zero));
                end
            end
            if (point.valid && point.ready)
                expected_q.push_back(track_point(point.pos_x, point.pos_y));
            mismatches <= fails;
            pending    <= expected_q.size();
        end
    end

endmodule

### tb/sv/path_curvature_window_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top of the path curvature window unit: clock, reset, stimulus, pacing, verdict.
module path_curvature_window_unit_tb import pcw_pkg::*;;

    // Nothing is accepted on either channel for this many cycles only when the unit hangs:
    // the slowest legal stretch is a long sender gap, a full window computation and a long
    // result stall.
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_POINTS = 1800;
    // After the last expected result, a full computation time more, with some margin.
    localparam int DRAIN_CYCLES  = 2 * WINDOW + 80;

    localparam int COORD_MAX = 2 ** (PT_W - 1) - 1;
    localparam int COORD_MIN = -(2 ** (PT_W - 1));

    // Shapes of the random path segments.
    typedef enum int {
        SCATTER,   // unrelated points over the whole field range
        WANDER,    // a random walk with small steps
        PARKED,    // a point that hardly moves, so the chord often has zero length
        CORNERS,   // coordinates taken from the field extremes and around zero
        STRAIGHT   // equal steps along a line, so the inner points sit on the chord
    } path_shape_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   idle_cycles;
    bit   send_calm;

    pcw_point_if  point ();
    pcw_result_if result ();

    path_curvature_window_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point),
        .result (result)
    );

    path_curvature_window_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Length of one idle stretch, with a long one now and then.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 93)
            return $urandom_range(3, 8);
        else
            return $urandom_range(30, 150);
    endfunction

    function automatic logic signed [PT_W-1:0] clamp_coord(input int v);
        if (v > COORD_MAX)
            return PT_W'(COORD_MAX);
        if (v < COORD_MIN)
            return PT_W'(COORD_MIN);
        return PT_W'(v);
    endfunction

    function automatic logic signed [PT_W-1:0] corner_coord();
        case ($urandom_range(0, 4))
            0:       return PT_W'(COORD_MIN);
            1:       return PT_W'(COORD_MAX);
            2:       return PT_W'(0);
            3:       return PT_W'(-1);
            default: return PT_W'(1);
        endcase
    endfunction

    // Offers one point on the point channel and returns once it has been transferred.
    // With no gap, valid simply stays high and only the payload changes.
    task automatic send_point(input int x, input int y);
        int gap;
        gap = (send_calm || $urandom_range(0, 1)) ? 0 : pick_idle();
        @(negedge clk);
        if (gap > 0)
        begin
            point.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        point.valid <= 1'b1;
        point.pos_x <= clamp_coord(x);
        point.pos_y <= clamp_coord(y);
        do
            @(posedge clk);
        while (point.ready !== 1'b1);
    endtask

    // Result side pacing. Calm phases keep ready high; busy phases stall at random, so
    // stalls land on every phase of the unit's work, including while it computes the
    // next point behind a result that still waits for its transfer.
    initial
    begin : result_pacing
        int  stall;
        int  phase_left;
        bit  calm;
        result.ready = 1'b0;
        stall        = 0;
        phase_left   = 0;
        calm         = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                calm       = ($urandom_range(0, 2) == 0);
                phase_left = $urandom_range(200, 600);
            end
            phase_left--;
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 30)
                    stall = pick_idle();
            end
        end
    end

    // A hung unit shows as a long stretch with no transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (point.valid && point.ready) || (result.valid && result.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("path_curvature_window_unit_tb: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        path_shape_t shape;
        int          seg_left;
        int          calm_left;
        int          walk_x;
        int          walk_y;
        int          step_x;
        int          step_y;
        rst_n       = 1'b0;
        point.valid = 1'b0;
        point.pos_x = '0;
        point.pos_y = '0;
        send_calm   = 1'b0;
        shape       = SCATTER;
        seg_left    = 0;
        calm_left   = 0;
        walk_x      = 0;
        walk_y      = 0;
        step_x      = 0;
        step_y      = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first seven points only fill the window: each result repeats the reset
        // error with error_valid low. The eighth completes the window and, being equal
        // to the oldest point, gives a zero-length chord.
        send_point(COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MAX);
        send_point(COORD_MAX, COORD_MIN);
        send_point(0, 0);
        send_point(-1, -1);
        send_point(1, 0);
        send_point(COORD_MIN, COORD_MIN);
        // Longest vertical chords on both sides of the field, then a zero chord again.
        send_point(COORD_MAX, COORD_MIN);
        send_point(COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MIN);
        // Very short chords with inner points far away: the largest distances the
        // coordinate range allows, of both signs.
        send_point(1, 1);
        send_point(0, 1);
        send_point(0, 0);
        send_point(0, COORD_MAX);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MAX);
        send_point(0, COORD_MAX);
        send_point(1, COORD_MAX);
        send_point(-1, COORD_MAX);
        send_point(1, 0);
        send_point(0, COORD_MIN);
        send_point(COORD_MAX, COORD_MIN);
        send_point(COORD_MIN, COORD_MIN);
        send_point(-1, 0);

        // Random path segments of mixed shapes.
        for (int n = 0; n < RANDOM_POINTS; n++)
        begin
            if (calm_left == 0)
            begin
                send_calm = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(40, 150);
            end
            calm_left--;
            if (seg_left == 0)
            begin
                shape    = path_shape_t'($urandom_range(0, 4));
                seg_left = $urandom_range(1, 40);
                walk_x   = int'(clamp_coord(int'($urandom_range(0, 2 * COORD_MAX + 1))
                                            + COORD_MIN));
                walk_y   = int'(clamp_coord(int'($urandom_range(0, 2 * COORD_MAX + 1))
                                            + COORD_MIN));
                if ($urandom_range(0, 1))
                begin
                    step_x = int'($urandom_range(0, 8)) - 4;
                    step_y = int'($urandom_range(0, 8)) - 4;
                end
                else
                begin
                    step_x = int'($urandom_range(0, 8192)) - 4096;
                    step_y = int'($urandom_range(0, 8192)) - 4096;
                end
            end
            seg_left--;
            case (shape)
                SCATTER:
                begin
                    walk_x = int'(signed'(PT_W'($urandom)));
                    walk_y = int'(signed'(PT_W'($urandom)));
                end
                WANDER:
                begin
                    walk_x = int'(clamp_coord(walk_x + int'($urandom_range(0, 16)) - 8));
                    walk_y = int'(clamp_coord(walk_y + int'($urandom_range(0, 16)) - 8));
                end
                PARKED:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        walk_x = int'(clamp_coord(walk_x + int'($urandom_range(0, 2)) - 1));
                        walk_y = int'(clamp_coord(walk_y + int'($urandom_range(0, 2)) - 1));
                    end
                end
                CORNERS:
                begin
                    walk_x = int'(corner_coord());
                    walk_y = int'(corner_coord());
                end
                default:
                begin
                    walk_x = int'(clamp_coord(walk_x + step_x));
                    walk_y = int'(clamp_coord(walk_y + step_y));
                end
            endcase
            send_point(walk_x, walk_y);
        end

        @(negedge clk);
        point.valid <= 1'b0;

        // Every point causes one result, so an empty store of expected results means
        // the unit is idle; the extra cycles catch any result it should not send.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("path_curvature_window_unit_tb: clean");
        else
            $display("path_curvature_window_unit_tb: errors");
        $finish;
    end

endmodule

### files.f
rtl/pcw_pkg.sv
rtl/pcw_if.sv
rtl/pcw_ram.sv
rtl/pcw_ctrl.sv
rtl/pcw_dp.sv
rtl/path_curvature_window_unit.sv
tb/sv/path_curvature_window_checker.sv
tb/sv/path_curvature_window_unit_tb.sv
